// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent assertions on a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at an edge, cons must hold at the same edge.
`define SPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds at an edge, cons must hold at the following edge.
`define SPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and coil pattern tables of the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Request codes as they arrive on the input.
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_FWD  = 3'd1;
  localparam logic [2:0] REQ_BACK = 3'd2;
  localparam logic [2:0] REQ_GOTO = 3'd3;
  localparam logic [2:0] REQ_STOP = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_DELAY = 2'd0;
  localparam logic [1:0] CFG_STEP_COUNT = 2'd1;
  localparam logic [1:0] CFG_STEP_MODE  = 2'd2;
  localparam logic [1:0] CFG_MOTOR_SLOT = 2'd3;

  localparam logic [23:0] STEP_DELAY_RST = 24'd1000;
  localparam logic [15:0] STEP_COUNT_RST = 16'd200;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Coil patterns for the first and second nibble slot.
  localparam logic [7:0] PAT_AC [2] = '{8'hF9, 8'h9F};
  localparam logic [7:0] PAT_AD [2] = '{8'hFA, 8'hAF};
  localparam logic [7:0] PAT_BC [2] = '{8'hF5, 8'h5F};
  localparam logic [7:0] PAT_BD [2] = '{8'hF6, 8'h6F};
  localparam logic [7:0] PAT_A  [2] = '{8'hFB, 8'hBF};
  localparam logic [7:0] PAT_B  [2] = '{8'hF4, 8'h4F};
  localparam logic [7:0] PAT_C  [2] = '{8'hFD, 8'hDF};
  localparam logic [7:0] PAT_D  [2] = '{8'hF2, 8'h2F};
  localparam logic [7:0] REL_MASK [2] = '{8'h0F, 8'hF0};

  typedef enum logic [2:0] {
    OP_TICK,
    OP_LOAD,
    OP_GOTO,
    OP_STOP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [24:0] amount;
    logic [15:0]        target;
  } cmd_t;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  drive_byte;
    logic [15:0] position;
    logic        is_stopped;
  } res_t;

  typedef struct packed {
    logic [23:0] step_delay;
    logic [15:0] step_count;
    logic        step_mode;
    logic        motor_slot;
  } cfg_t;

  function automatic logic [7:0] phase_pattern(logic [2:0] phase, logic mode, logic slot);
    logic [7:0] pat;
    pat = 8'hFF;
    if (!mode) begin
      unique case (phase[1:0])
        2'd0:    pat = PAT_AC[slot];
        2'd1:    pat = PAT_BC[slot];
        2'd2:    pat = PAT_BD[slot];
        default: pat = PAT_AD[slot];
      endcase
    end else begin
      unique case (phase)
        3'd0:    pat = PAT_C[slot];
        3'd1:    pat = PAT_BC[slot];
        3'd2:    pat = PAT_B[slot];
        3'd3:    pat = PAT_BD[slot];
        3'd4:    pat = PAT_D[slot];
        3'd5:    pat = PAT_AD[slot];
        3'd6:    pat = PAT_A[slot];
        default: pat = PAT_AC[slot];
      endcase
    end
    return pat;
  endfunction

endpackage

// ===== rtl/sps_queue.sv =====
// ----------------------------------------------------------------------------
// sps_queue
// Small first-in first-out register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sps_queue #(
  parameter int  Depth = 2,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/sps_front.sv =====
// ----------------------------------------------------------------------------
// sps_front
// Classifies an incoming request and prepares its signed step amount.
// ----------------------------------------------------------------------------
module sps_front (
  input  logic            [2:0]  req_type_i,
  input  logic            [23:0] step_amount_i,
  input  logic            [15:0] target_position_i,
  output sps_pkg::cmd_t          cmd_o
);

  logic signed [24:0] amount_ext;

  assign amount_ext = $signed({1'b0, step_amount_i});

  always_comb begin
    cmd_o.target = target_position_i;
    cmd_o.amount = amount_ext;
    unique case (req_type_i)
      sps_pkg::REQ_TICK: cmd_o.op = sps_pkg::OP_TICK;
      sps_pkg::REQ_FWD:  cmd_o.op = sps_pkg::OP_LOAD;
      sps_pkg::REQ_BACK: begin
        cmd_o.op     = sps_pkg::OP_LOAD;
        cmd_o.amount = -amount_ext;
      end
      sps_pkg::REQ_GOTO: cmd_o.op = sps_pkg::OP_GOTO;
      sps_pkg::REQ_STOP: cmd_o.op = sps_pkg::OP_STOP;
      default:           cmd_o.op = sps_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/sps_mod.sv =====
// ----------------------------------------------------------------------------
// sps_mod
// Bit-serial remainder unit: one restoring step per cycle over 17 bits.
// ----------------------------------------------------------------------------
module sps_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  localparam int DivW = 17;

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [DivW-1:0]   num_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   trial;
  logic [DivW-1:0]   rem_next;

  // The running remainder stays below the divisor, so 16 bits plus the new bit fit.
  assign trial    = {rem_q[DivW-2:0], num_q[DivW-1]};
  assign rem_next = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
  assign done_o   = done_q;
  assign rem_o    = rem_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivW-2:0], 1'b0};
      rem_q <= rem_next;
    end
  end

endmodule

// ===== rtl/sps_back.sv =====
// ----------------------------------------------------------------------------
// sps_back
// Executes queued requests against the motor state and forms one result each.
// ----------------------------------------------------------------------------
module sps_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sps_pkg::cfg_t cfg_i,
  input  sps_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output sps_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_MOD = 2'b10
  } back_state_e;

  back_state_e        state_q, state_d;
  logic signed [24:0] rem_q, rem_d;
  logic [15:0]        pos_q, pos_d;
  logic [2:0]         last_q, last_d;
  logic [24:0]        el_q, el_d;
  logic [7:0]         ob_q, ob_d;
  logic               mod_have_q, mod_have_d;

  logic [24:0] inc_el;
  logic        step_ok;
  logic        rem_pos;
  logic [16:0] pos_inc;
  logic [16:0] count_ext;
  logic        fwd_oor;
  logic [15:0] fwd_pos;
  logic [15:0] bwd_pos;
  logic [15:0] step_pos;
  logic [2:0]  phase;
  logic [7:0]  rel;
  logic [7:0]  ob_step;
  logic        mod_needed;
  logic        mod_start;
  logic        mod_done;
  logic [15:0] mod_rem;
  logic        fire;

  sps_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (pos_inc),
    .divisor_i  (cfg_i.step_count),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign inc_el    = (el_q == '1) ? el_q : el_q + 25'd1;
  assign step_ok   = inc_el > {1'b0, cfg_i.step_delay};
  assign rem_pos   = rem_q > 25'sd0;
  assign pos_inc   = {1'b0, pos_q} + 17'd1;
  assign count_ext = {1'b0, cfg_i.step_count};
  assign rel       = sps_pkg::REL_MASK[cfg_i.motor_slot];

  // A position left beyond a reduced step count needs a true remainder.
  always_comb begin
    fwd_oor = 1'b0;
    fwd_pos = pos_inc[15:0];
    if (cfg_i.step_count == '0) begin
      fwd_pos = pos_inc[15:0];
    end else if (pos_inc == count_ext) begin
      fwd_pos = '0;
    end else if (pos_inc > count_ext) begin
      fwd_oor = 1'b1;
      fwd_pos = mod_rem;
    end
  end

  assign bwd_pos    = (pos_q == '0) ? cfg_i.step_count - 16'd1 : pos_q - 16'd1;
  assign step_pos   = rem_pos ? fwd_pos : bwd_pos;
  assign phase      = cfg_i.step_mode ? step_pos[2:0] : {1'b0, step_pos[1:0]};
  assign mod_needed = (cmd_i.op == sps_pkg::OP_TICK) && (rem_q != '0) && step_ok
                      && rem_pos && fwd_oor;

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    last_d     = last_q;
    el_d       = el_q;
    ob_d       = ob_q;
    mod_have_d = mod_have_q;
    mod_start  = 1'b0;
    fire       = 1'b0;
    ob_step    = ob_q | rel;
    res_o      = '0;

    unique case (state_q)
      ST_RUN: begin
        if (!cmd_empty_i && !res_full_i) begin
          if (mod_needed && !mod_have_q) begin
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end else begin
            fire       = 1'b1;
            mod_have_d = 1'b0;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          mod_have_d = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase

    if (fire) begin
      case (cmd_i.op)
        sps_pkg::OP_TICK: begin
          el_d = inc_el;
          if (rem_q == '0) begin
            ob_d              = ob_q & rel;
            res_o.write_valid = 1'b1;
          end else if (step_ok) begin
            rem_d = rem_pos ? rem_q - 25'sd1 : rem_q + 25'sd1;
            pos_d = step_pos;
            if (phase != last_q) begin
              last_d  = phase;
              ob_step = ob_step & sps_pkg::phase_pattern(phase, cfg_i.step_mode,
                                                         cfg_i.motor_slot);
              el_d    = '0;
            end
            ob_d              = ob_step;
            res_o.write_valid = 1'b1;
            res_o.drive_byte  = ob_step;
          end
        end
        sps_pkg::OP_LOAD: rem_d = cmd_i.amount;
        sps_pkg::OP_GOTO: rem_d = $signed({9'd0, cmd_i.target} - {9'd0, pos_q});
        sps_pkg::OP_STOP: begin
          ob_d              = ob_q & rel;
          rem_d             = '0;
          res_o.write_valid = 1'b1;
          res_o.drive_byte  = ob_q & rel;
        end
        default: ;
      endcase
    end

    res_o.position   = pos_d;
    res_o.is_stopped = (rem_d == '0);
  end

  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      rem_q      <= '0;
      pos_q      <= '0;
      last_q     <= '0;
      el_q       <= '1;
      ob_q       <= '0;
      mod_have_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      last_q     <= last_d;
      el_q       <= el_d;
      ob_q       <= ob_d;
      mod_have_q <= mod_have_d;
    end
  end

endmodule

// ===== rtl/stepper_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Full and half step coil sequencer driving one nibble of an expander byte.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   -------   --------------   ----------------------------------------------
//   request   push_i / full_o  req_type_i, step_amount_i, target_position_i
//   result    pop_i / empty_o  write_valid_o, drive_byte_o, position_o,
//                              is_stopped_o
//   config    cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// One request is taken per cycle while full_o is low; it passes the request
// queue and then the result queue before it appears on the result ports. A
// forward step from a position at or beyond the step count waits in the
// bit-serial remainder unit; every other request executes directly.
// Reset is asynchronous and clears both queues and the motor state; elapsed
// time starts saturated so the first step is never held off. A stalled
// result side fills the result queue, then the request queue, then full_o.
//
module stepper_phase_sequencer #(
  parameter int CmdDepth = sps_pkg::CMD_DEPTH,
  parameter int ResDepth = sps_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side.
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  req_type_i,
  input  logic [23:0] step_amount_i,
  input  logic [15:0] target_position_i,
  // Result side.
  output logic        empty_o,
  input  logic        pop_i,
  output logic        write_valid_o,
  output logic [7:0]  drive_byte_o,
  output logic [15:0] position_o,
  output logic        is_stopped_o,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  sps_pkg::cfg_t cfg_q;
  sps_pkg::cmd_t cmd_in;
  sps_pkg::cmd_t cmd_head;
  sps_pkg::res_t res_in;
  sps_pkg::res_t res_head;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;

  // The user must ensure configuration is only written while the block is idle, so
  // the back end reads these registers directly; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_delay <= sps_pkg::STEP_DELAY_RST;
      cfg_q.step_count <= sps_pkg::STEP_COUNT_RST;
      cfg_q.step_mode  <= 1'b0;
      cfg_q.motor_slot <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sps_pkg::CFG_STEP_DELAY: cfg_q.step_delay <= cfg_wdata_i;
        sps_pkg::CFG_STEP_COUNT: cfg_q.step_count <= cfg_wdata_i[15:0];
        sps_pkg::CFG_STEP_MODE:  cfg_q.step_mode  <= cfg_wdata_i[0];
        default:                 cfg_q.motor_slot <= cfg_wdata_i[0];
      endcase
    end
  end

  // The front end classifies each request on its way into the request queue.
  sps_front u_front (
    .req_type_i        (req_type_i),
    .step_amount_i     (step_amount_i),
    .target_position_i (target_position_i),
    .cmd_o             (cmd_in)
  );

  sps_queue #(
    .Depth (CmdDepth),
    .T     (sps_pkg::cmd_t)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  // The back end owns the motor state and retires one request per transfer
  // into the result queue.
  sps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  sps_queue #(
    .Depth (ResDepth),
    .T     (sps_pkg::res_t)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_head),
    .empty_o (empty_o)
  );

  assign write_valid_o = res_head.write_valid;
  assign drive_byte_o  = res_head.drive_byte;
  assign position_o    = res_head.position;
  assign is_stopped_o  = res_head.is_stopped;

endmodule

// ===== rtl/sps_checker.sv =====
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks of the stepper phase sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic        write_valid_o,
  input logic [7:0]  drive_byte_o,
  input logic [15:0] position_o,
  input logic        is_stopped_o
);

  logic        have_q;
  logic [15:0] last_pos_q;

  // Position of the most recently transferred result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      last_pos_q <= '0;
    end else if (pop_i && !empty_o) begin
      have_q     <= 1'b1;
      last_pos_q <= position_o;
    end
  end

  `SPS_ASSERT_NOW(a_no_byte_without_write, clk_i, rst_ni, !empty_o && !write_valid_o, drive_byte_o == 8'h00, "byte nonzero without a write")

  `SPS_ASSERT_NOW(a_move_only_with_write, clk_i, rst_ni, !empty_o && !write_valid_o && have_q, position_o == last_pos_q, "position moved without a byte write")

  `SPS_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(position_o) && $stable(drive_byte_o) && $stable(is_stopped_o), "waiting result changed")

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .write_valid_o (write_valid_o),
  .drive_byte_o  (drive_byte_o),
  .position_o    (position_o),
  .is_stopped_o  (is_stopped_o)
);

// ===== tb/stepper_phase_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_tb
// Self-checking testbench: drives requests and configuration writes into the
// sequencer, predicts every coil byte, position and stop flag, and compares
// each popped result with the oldest prediction under random idling on both
// sides.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung. The slowest
  // correct gap is a sender pause, a long remainder step and a receiver stall,
  // with a configuration burst on top.
  localparam int StallLimit = 2000;
  // Cycles to linger after the last result, to catch any stray result.
  localparam int SettleCycles = 40;
  localparam int PhaseItems = 72;

  // --------------------------------------------------------------------------
  // Prediction of the coil driver and store of the results it expects.
  // --------------------------------------------------------------------------
  class drive_predictor;
    sps_pkg::cfg_t      cfg;
    logic signed [24:0] steps_left;
    logic [15:0]        pos;
    logic [2:0]         last_ph;
    logic [24:0]        since_change;
    logic [7:0]         coil_byte;
    sps_pkg::res_t      expected_drives[$];
    int                 mismatches;
    int                 requests;
    int                 steps_moved;
    int                 phase_changes;
    int                 releases;
    int                 stops;

    function new();
      cfg.step_delay = sps_pkg::STEP_DELAY_RST;
      cfg.step_count = sps_pkg::STEP_COUNT_RST;
      cfg.step_mode  = 1'b0;
      cfg.motor_slot = 1'b0;
      steps_left     = '0;
      pos            = '0;
      last_ph        = '0;
      since_change   = '1;
      coil_byte      = '0;
      mismatches     = 0;
      requests       = 0;
      steps_moved    = 0;
      phase_changes  = 0;
      releases       = 0;
      stops          = 0;
    endfunction

    function void set_config(sps_pkg::cfg_t c);
      cfg = c;
    endfunction

    function int outstanding();
      return expected_drives.size();
    endfunction

    function logic [7:0] coil_pattern(logic [2:0] ph, logic s);
      if (!cfg.step_mode) begin
        case (ph[1:0])
          2'd0:    return sps_pkg::PAT_AC[s];
          2'd1:    return sps_pkg::PAT_BC[s];
          2'd2:    return sps_pkg::PAT_BD[s];
          default: return sps_pkg::PAT_AD[s];
        endcase
      end
      case (ph)
        3'd0:    return sps_pkg::PAT_C[s];
        3'd1:    return sps_pkg::PAT_BC[s];
        3'd2:    return sps_pkg::PAT_B[s];
        3'd3:    return sps_pkg::PAT_BD[s];
        3'd4:    return sps_pkg::PAT_D[s];
        3'd5:    return sps_pkg::PAT_AD[s];
        3'd6:    return sps_pkg::PAT_A[s];
        default: return sps_pkg::PAT_AC[s];
      endcase
    endfunction

    // Works out the result of one accepted request and queues it.
    function void take_request(logic [2:0] req, logic [23:0] amt, logic [15:0] tgt);
      sps_pkg::res_t r;
      logic [16:0]   modulus;
      logic [16:0]   nxt;
      logic [2:0]    ph;
      logic          s;
      s       = cfg.motor_slot;
      modulus = (cfg.step_count == 16'd0) ? 17'h10000 : {1'b0, cfg.step_count};
      r       = '0;
      requests++;
      case (req)
        sps_pkg::REQ_TICK: begin
          if (since_change != '1) since_change++;
          if (steps_left == 0) begin
            coil_byte     = coil_byte & sps_pkg::REL_MASK[s];
            r.write_valid = 1'b1;
            releases++;
          end else if (since_change > {1'b0, cfg.step_delay}) begin
            if (steps_left > 0) begin
              steps_left--;
              nxt = ({1'b0, pos} + 17'd1) % modulus;
              pos = nxt[15:0];
            end else begin
              steps_left++;
              if (pos == 16'd0) pos = 16'(modulus - 17'd1);
              else pos = pos - 16'd1;
            end
            steps_moved++;
            ph        = cfg.step_mode ? pos[2:0] : {1'b0, pos[1:0]};
            coil_byte = coil_byte | sps_pkg::REL_MASK[s];
            if (ph != last_ph) begin
              last_ph      = ph;
              coil_byte    = coil_byte & coil_pattern(ph, s);
              since_change = '0;
              phase_changes++;
            end
            r.write_valid = 1'b1;
            r.drive_byte  = coil_byte;
          end
        end
        sps_pkg::REQ_FWD:  steps_left = $signed({1'b0, amt});
        sps_pkg::REQ_BACK: steps_left = -$signed({1'b0, amt});
        sps_pkg::REQ_GOTO: steps_left = $signed({9'd0, tgt}) - $signed({9'd0, pos});
        sps_pkg::REQ_STOP: begin
          coil_byte     = coil_byte & sps_pkg::REL_MASK[s];
          steps_left    = '0;
          r.write_valid = 1'b1;
          r.drive_byte  = coil_byte;
          stops++;
        end
        default: ;
      endcase
      r.position   = pos;
      r.is_stopped = (steps_left == 0);
      expected_drives.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compares one popped result with the oldest prediction.
    task check_drive(sps_pkg::res_t got);
      sps_pkg::res_t want;
      if (expected_drives.size() == 0) begin
        report("result popped with nothing expected");
        return;
      end
      want = expected_drives.pop_front();
      if (got.write_valid !== want.write_valid)
        report($sformatf("write_valid %b, expected %b", got.write_valid, want.write_valid));
      if (got.drive_byte !== want.drive_byte)
        report($sformatf("drive_byte %h, expected %h", got.drive_byte, want.drive_byte));
      if (got.position !== want.position)
        report($sformatf("position %0d, expected %0d", got.position, want.position));
      if (got.is_stopped !== want.is_stopped)
        report($sformatf("is_stopped %b, expected %b", got.is_stopped, want.is_stopped));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  logic [2:0]  req_type_i;
  logic [23:0] step_amount_i;
  logic [15:0] target_position_i;
  logic        empty_o;
  logic        pop_i;
  logic        write_valid_o;
  logic [7:0]  drive_byte_o;
  logic [15:0] position_o;
  logic        is_stopped_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  drive_predictor drives;
  bit             send_quiet;
  bit             take_quiet;
  int             quiet_cycles;
  int             settings_used;

  stepper_phase_sequencer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_o            (full_o),
    .req_type_i        (req_type_i),
    .step_amount_i     (step_amount_i),
    .target_position_i (target_position_i),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .write_valid_o     (write_valid_o),
    .drive_byte_o      (drive_byte_o),
    .position_o        (position_o),
    .is_stopped_o      (is_stopped_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog restarts its count on every transfer on either side. If the
  // block stops moving for far longer than any correct run would, it ends
  // the run as a failure.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All of them are entered and left on a rising clock edge.
  // --------------------------------------------------------------------------

  function automatic sps_pkg::cfg_t make_cfg(logic [23:0] delay, logic [15:0] count,
                                             logic mode, logic slot);
    sps_pkg::cfg_t c;
    c.step_delay = delay;
    c.step_count = count;
    c.step_mode  = mode;
    c.motor_slot = slot;
    return c;
  endfunction

  // One register write takes effect at the next edge; the enable is left high
  // so that back-to-back writes follow one another without a gap.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Writes all four registers. Only called while the block is idle.
  task automatic apply_config(input sps_pkg::cfg_t c);
    write_reg(sps_pkg::CFG_STEP_DELAY, c.step_delay);
    write_reg(sps_pkg::CFG_STEP_COUNT, {8'd0, c.step_count});
    write_reg(sps_pkg::CFG_STEP_MODE,  {23'd0, c.step_mode});
    write_reg(sps_pkg::CFG_MOTOR_SLOT, {23'd0, c.motor_slot});
    cfg_we_i <= 1'b0;
    drives.set_config(c);
    settings_used++;
  endtask

  // Offers one request after a random pause and returns at the edge where
  // the transfer in takes place. Every so often the sender switches between
  // pausing and streaming back to back, so that both patterns occur.
  task automatic send_request(input logic [2:0] req, input logic [23:0] amt,
                              input logic [15:0] tgt);
    int gap;
    if ($urandom_range(0, 24) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i            <= 1'b1;
    req_type_i        <= req;
    step_amount_i     <= amt;
    target_position_i <= tgt;
    do @(posedge clk_i); while (full_o);
    drives.take_request(req, amt, tgt);
  endtask

  // Holds the request side off until every expected result has been popped.
  // It always waits on the clock before it first checks, so push is lowered in
  // a step of its own.
  task automatic wait_drained();
    push_i <= 1'b0;
    do @(posedge clk_i); while (drives.outstanding() != 0);
  endtask

  // One random request. Ticks dominate so that moves really play out; most
  // moves are short, and goto targets mostly lie near the position or within
  // the step count, with full-range values now and then.
  task automatic send_random();
    logic [2:0]  req;
    logic [23:0] amt;
    logic [15:0] tgt;
    int          pick;
    pick = $urandom_range(0, 99);
    amt  = 24'($urandom);
    tgt  = 16'($urandom);
    if (pick < 55) begin
      req = sps_pkg::REQ_TICK;
    end else if (pick < 67) begin
      req = sps_pkg::REQ_FWD;
      if ($urandom_range(0, 7) != 0) amt = 24'($urandom_range(0, 12));
    end else if (pick < 79) begin
      req = sps_pkg::REQ_BACK;
      if ($urandom_range(0, 7) != 0) amt = 24'($urandom_range(0, 12));
    end else if (pick < 88) begin
      req = sps_pkg::REQ_GOTO;
      case ($urandom_range(0, 3))
        0: ;
        1: tgt = 16'($urandom_range(0, (drives.cfg.step_count == 16'd0) ? 65535 :
                                        drives.cfg.step_count));
        default: tgt = drives.pos + 16'($urandom_range(0, 16)) - 16'd8;
      endcase
    end else if (pick < 95) begin
      req = sps_pkg::REQ_STOP;
    end else begin
      // Codes beyond the last defined request leave the motor state alone but still yield a result.
      req = sps_pkg::REQ_STOP + 3'($urandom_range(1, 3));
    end
    send_request(req, amt, tgt);
  endtask

  // --------------------------------------------------------------------------
  // Result side: pops with random stalls and checks every transfer out.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int            stall;
    sps_pkg::res_t got;
    pop_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 24) == 0) take_quiet = !take_quiet;
      stall = take_quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        pop_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      got.write_valid = write_valid_o;
      got.drive_byte  = drive_byte_o;
      got.position    = position_o;
      got.is_stopped  = is_stopped_o;
      drives.check_drive(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sps_pkg::cfg_t plan [7];
    drives            = new();
    quiet_cycles      = 0;
    settings_used     = 1;
    rst_ni            <= 1'b0;
    push_i            <= 1'b0;
    req_type_i        <= sps_pkg::REQ_TICK;
    step_amount_i     <= '0;
    target_position_i <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= sps_pkg::CFG_STEP_DELAY;
    cfg_wdata_i       <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings. Elapsed time starts saturated,
    // so the first step goes through at once even with the long reset delay;
    // the following tick is then too early.
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_FWD, 24'd3, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'hFFFFFF, 16'hFFFF);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_STOP, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_STOP + 3'd3, 24'hFFFFFF, 16'hFFFF);
    send_request(sps_pkg::REQ_GOTO, 24'd0, 16'hFFFF);
    send_request(sps_pkg::REQ_BACK, 24'hFFFFFF, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    wait_drained();

    // Five steps per revolution on the second slot in full step mode: the
    // step from 4 to 0 and back leaves the phase unchanged, so the nibble
    // stays all ones and the timer keeps running.
    apply_config(make_cfg(24'd0, 16'd5, 1'b0, 1'b1));
    send_request(sps_pkg::REQ_BACK, 24'd2, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_FWD, 24'd1, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_GOTO, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    wait_drained();

    // A step count of zero stands for a full 16-bit revolution: stepping back
    // from 0 lands on 65535.
    apply_config(make_cfg(24'd0, 16'd0, 1'b1, 1'b0));
    send_request(sps_pkg::REQ_BACK, 24'd1, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    wait_drained();

    // Shrinking the revolution leaves the position beyond the step count; the
    // next forward step takes the remainder and is the slow case of the block.
    apply_config(make_cfg(24'd0, 16'd3, 1'b1, 1'b0));
    send_request(sps_pkg::REQ_FWD, 24'd1, 16'd0);
    send_request(sps_pkg::REQ_TICK, 24'd0, 16'd0);
    send_request(sps_pkg::REQ_STOP, 24'd0, 16'd0);
    wait_drained();

    // Random part, one block of requests per setting. The order matters: the
    // full 16-bit revolution lets the position run far out, so that the
    // single-step revolution after it starts beyond its step count. The
    // longest delay keeps nearly every tick too early.
    plan[0] = make_cfg(24'd0, 16'd7, 1'b0, 1'b0);
    plan[1] = make_cfg(24'd2, 16'd5, 1'b1, 1'b1);
    plan[2] = make_cfg(24'd1, 16'd0, 1'b1, 1'b0);
    plan[3] = make_cfg(24'd0, 16'd1, 1'b0, 1'b1);
    plan[4] = make_cfg(24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1);
    plan[5] = make_cfg(24'd3, 16'd3, 1'b0, 1'b0);
    plan[6] = make_cfg(24'($urandom_range(0, 4)), 16'($urandom_range(1, 16)),
                       1'($urandom), 1'($urandom));
    foreach (plan[p]) begin
      apply_config(plan[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        send_random();
        // Now and then, and once in every block for certain, the sender holds
        // off until the result side has caught up completely.
        if (n == PhaseItems / 2 || $urandom_range(0, 59) == 0) wait_drained();
      end
      wait_drained();
    end

    // Everything has been popped; linger a little so that a stray result
    // would still be caught as unexpected.
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d requests under %0d register settings, both slots and step modes.",
             drives.requests, settings_used);
    $display("Coil steps %0d, phase changes %0d, idle releases %0d, stops %0d, mismatches %0d.",
             drives.steps_moved, drives.phase_changes, drives.releases, drives.stops,
             drives.mismatches);
    if (drives.mismatches == 0 && drives.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
